// File: hdl/ffcas_pkg.sv
// Package: constants, codes and result type for the fixed frame checker.
package ffcas_pkg;

  localparam int HEADER_BYTES_DEF = 1;
  localparam int MAX_PAYLOAD_DEF  = 16;
  localparam int FRAME_BYTES_DEF  = 22;

  localparam logic [7:0] HEADER_RESET = 8'h11;

  localparam int LEN_W   = 16;
  localparam int SUM_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 4;
  localparam int PLEN_W  = 5;
  localparam int ODATA_W = 24;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_HDR_BAD = 2'd1,
    VERDICT_LEN_BAD = 2'd2,
    VERDICT_SUM_BAD = 2'd3
  } verdict_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [IDX_W-1:0]    payload_index;
    verdict_t            verdict;
    logic [PLEN_W-1:0]   payload_length;
  } result_t;

endpackage

// File: hdl/fixed_frame_checker_additive_sum.sv
// Fixed-length frame checker with 16-bit additive checksum, top level.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_tvalid in_tready in_tdata in_tuser| sink
//  out     | out_tvalid out_tready out_tdata      | source
//          | out_tuser                            |
//  cfg     | cfg_valid cfg_ready cfg_data         | sink
//
// One beat per cycle in while in_tready is high; results are registered.
// Frame state updates in the same cycle a beat is taken.
// A two-entry output stage (result reg + skid reg) keeps in_tready high
// while one result waits; in_tready drops only when both are full.
// rst_n is synchronous: clears frame state, header reg back to 0x11.
module fixed_frame_checker_additive_sum #(
  parameter int HEADER_BYTES = ffcas_pkg::HEADER_BYTES_DEF,
  parameter int MAX_PAYLOAD  = ffcas_pkg::MAX_PAYLOAD_DEF,
  parameter int FRAME_BYTES  = ffcas_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] payload_byte, [11:8] payload_index,
                                  // [13:12] verdict, [18:14] payload_length
  output logic        out_tuser,  // [0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // header_word
);

  localparam int POS_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [ffcas_pkg::LEN_W-1:0] LAST_POS16 =
    ffcas_pkg::LEN_W'(FRAME_BYTES - 1);
  localparam logic [ffcas_pkg::LEN_W-1:0] CSUM_HI_POS16 =
    ffcas_pkg::LEN_W'(FRAME_BYTES - 2);
  localparam logic [ffcas_pkg::LEN_W-1:0] HDR16 = ffcas_pkg::LEN_W'(HEADER_BYTES);
  localparam logic [ffcas_pkg::LEN_W-1:0] LEN_LO_POS16 =
    ffcas_pkg::LEN_W'(HEADER_BYTES + 1);
  localparam logic [ffcas_pkg::LEN_W-1:0] PLD_OFS16 = ffcas_pkg::LEN_W'(HEADER_BYTES + 2);
  localparam logic [ffcas_pkg::LEN_W-1:0] MAX_PLD16 = ffcas_pkg::LEN_W'(MAX_PAYLOAD);

  logic [7:0]                     hdr_word_r;
  logic [POS_W-1:0]               pos_r, pos_nxt;
  logic                           hdr_ok_r, hdr_ok_nxt;
  logic [ffcas_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [ffcas_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [7:0]                     csum_hi_r, csum_hi_nxt;

  ffcas_pkg::result_t             out_res_r, out_res_nxt;
  logic                           out_vld_r, out_vld_nxt;
  ffcas_pkg::result_t             skid_res_r, skid_res_nxt;
  logic                           skid_vld_r, skid_vld_nxt;

  logic                           in_acc;
  logic [7:0]                     b;
  logic [POS_W-1:0]               p;
  logic [ffcas_pkg::LEN_W-1:0]    p16, idx16;
  logic                           hm;
  logic [ffcas_pkg::LEN_W-1:0]    len;
  logic [ffcas_pkg::SUM_W-1:0]    sum;
  logic [7:0]                     csh;
  logic [ffcas_pkg::SUM_W-1:0]    got;
  ffcas_pkg::result_t             res;
  logic                           has_res;
  ffcas_pkg::verdict_t            vrd;

  assign in_tready = !skid_vld_r;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign b   = in_tdata;
  assign p   = in_tuser ? '0 : pos_r;
  assign hm  = in_tuser ? 1'b1 : hdr_ok_r;
  assign len = in_tuser ? '0 : len_r;
  assign sum = in_tuser ? '0 : sum_r;
  assign csh = in_tuser ? '0 : csum_hi_r;
  assign p16 = ffcas_pkg::LEN_W'(p);
  assign idx16 = p16 - PLD_OFS16;
  assign got = {csh, b};

  always_comb begin
    if (!hm) begin
      vrd = ffcas_pkg::VERDICT_HDR_BAD;
    end else if (len > MAX_PLD16) begin
      vrd = ffcas_pkg::VERDICT_LEN_BAD;
    end else if (sum != got) begin
      vrd = ffcas_pkg::VERDICT_SUM_BAD;
    end else begin
      vrd = ffcas_pkg::VERDICT_OK;
    end
  end

  always_comb begin
    pos_nxt     = p + POS_W'(1);
    hdr_ok_nxt  = hm;
    len_nxt     = len;
    sum_nxt     = sum;
    csum_hi_nxt = csh;
    has_res     = 1'b0;
    res         = '0;
    if (p16 >= LAST_POS16) begin
      has_res            = 1'b1;
      res.kind           = ffcas_pkg::KIND_VERDICT;
      res.verdict        = vrd;
      res.payload_length = (vrd == ffcas_pkg::VERDICT_OK || vrd == ffcas_pkg::VERDICT_SUM_BAD)
                           ? len[ffcas_pkg::PLEN_W-1:0] : '0;
      pos_nxt            = '0;
      hdr_ok_nxt         = 1'b1;
      len_nxt            = '0;
      sum_nxt            = '0;
      csum_hi_nxt        = '0;
    end else if (p16 == CSUM_HI_POS16) begin
      csum_hi_nxt = b;
    end else if (p16 < HDR16) begin
      if (b != hdr_word_r) begin
        hdr_ok_nxt = 1'b0;
      end
    end else if (p16 == HDR16) begin
      len_nxt = {b, 8'h00};
    end else if (p16 == LEN_LO_POS16) begin
      len_nxt = {len[15:8], b};
    end else if (hm && (len <= MAX_PLD16) && (idx16 < len)) begin
      sum_nxt           = sum + ffcas_pkg::SUM_W'(b);
      has_res           = 1'b1;
      res.kind          = ffcas_pkg::KIND_PAYLOAD;
      res.payload_byte  = b;
      res.payload_index = idx16[ffcas_pkg::IDX_W-1:0];
    end
  end

  // output register with skid
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = in_acc && has_res;
        out_res_nxt = res;
      end
    end else if (in_acc && has_res) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_word_r <= ffcas_pkg::HEADER_RESET;
      pos_r      <= '0;
      hdr_ok_r   <= 1'b1;
      len_r      <= '0;
      sum_r      <= '0;
      csum_hi_r  <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hdr_word_r <= cfg_data;
      end
      if (in_acc) begin
        pos_r     <= pos_nxt;
        hdr_ok_r  <= hdr_ok_nxt;
        len_r     <= len_nxt;
        sum_r     <= sum_nxt;
        csum_hi_r <= csum_hi_nxt;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {5'b0, out_res_r.payload_length, out_res_r.verdict,
                       out_res_r.payload_index, out_res_r.payload_byte};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ffcas_pkg::LEN_W'(pos_r) <= LAST_POS16)
    else $error("frame position past last byte");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready && in_acc && has_res) |=> skid_vld_r)
    else $error("result lost on stalled output");

  a_verdict_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.kind == ffcas_pkg::KIND_VERDICT)
      |-> (out_res_r.payload_byte == '0 && out_res_r.payload_index == '0))
    else $error("verdict beat carries payload data");

  a_len_bad_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.kind == ffcas_pkg::KIND_VERDICT &&
     out_res_r.verdict == ffcas_pkg::VERDICT_LEN_BAD) |-> out_res_r.payload_length == '0)
    else $error("length reported on length-too-large verdict");

endmodule
